[hw/rtl/sss_pkg.sv]
// ----------------------------------------------------------------------------
// sss_pkg: shared widths, coefficients and payload types for the sound speed
// pipeline.
// Coefficients are the Mackenzie terms scaled by 2^56 and rounded half up.
// ----------------------------------------------------------------------------
`default_nettype none

package sss_pkg;

  // Port field widths.
  localparam int TEMP_W  = 15;
  localparam int SAL_W   = 14;
  localparam int DEPTH_W = 18;
  localparam int SPEED_W = 21;

  // Clamped operand widths.
  localparam int T_W  = 14;
  localparam int D_W  = 17;
  localparam int SD_W = 15;

  // Power product widths.
  localparam int T2_W  = 2 * T_W;
  localparam int D2_W  = 2 * D_W;
  localparam int TSD_W = T_W + SD_W;
  localparam int TD_W  = T_W + D_W;
  localparam int T3_W  = T2_W + T_W;
  localparam int TD3_W = TD_W + D2_W;

  // Salinity limits in input units (40 ppt and 35 ppt).
  localparam logic [SAL_W-1:0]        SAL_MAX = 14'd10240;
  localparam logic signed [SD_W-1:0]  SAL_REF = 15'sd8960;

  // Coefficient widths; three wide coefficients are split into halves.
  localparam int C0_W  = 67;
  localparam int C1_W  = 59;
  localparam int C2_W  = 52;
  localparam int C2L_W = 26;
  localparam int C2H_W = C2_W - C2L_W;
  localparam int C3_W  = 44;
  localparam int C3L_W = 22;
  localparam int C3H_W = C3_W - C3L_W;
  localparam int C4_W  = 57;
  localparam int C5_W  = 51;
  localparam int C6_W  = 34;
  localparam int C7_W  = 50;
  localparam int C7L_W = 25;
  localparam int C7H_W = C7_W - C7L_W;
  localparam int C8_W  = 16;

  // round_half_up(m * 10^-e * 2^56) = (m * 2^(57-e) + 5^e) / (2 * 5^e)
  localparam logic [127:0] C0_FULL = ((128'd144896 << 55) + 128'd25) / 128'd50;
  localparam logic [127:0] C1_FULL = ((128'd4591 << 54) + 128'd125) / 128'd250;
  localparam logic [127:0] C2_FULL = ((128'd5304 << 52) + 128'd3125) / 128'd6250;
  localparam logic [127:0] C3_FULL = ((128'd2374 << 50) + 128'd78125) / 128'd156250;
  localparam logic [127:0] C4_FULL = ((128'd134 << 55) + 128'd25) / 128'd50;
  localparam logic [127:0] C5_FULL = ((128'd163 << 53) + 128'd625) / 128'd1250;
  localparam logic [127:0] C6_FULL =
    ((128'd1675 << 47) + 128'd9765625) / 128'd19531250;
  localparam logic [127:0] C7_FULL = ((128'd1025 << 52) + 128'd3125) / 128'd6250;
  localparam logic [127:0] C8_FULL =
    ((128'd7139 << 41) + 128'd152587890625) / 128'd305175781250;

  localparam logic [C0_W-1:0]  C0  = C0_FULL[C0_W-1:0];
  localparam logic [C1_W-1:0]  C1  = C1_FULL[C1_W-1:0];
  localparam logic [C2H_W-1:0] C2H = C2_FULL[C2_W-1:C2L_W];
  localparam logic [C2L_W-1:0] C2L = C2_FULL[C2L_W-1:0];
  localparam logic [C3H_W-1:0] C3H = C3_FULL[C3_W-1:C3L_W];
  localparam logic [C3L_W-1:0] C3L = C3_FULL[C3L_W-1:0];
  localparam logic [C4_W-1:0]  C4  = C4_FULL[C4_W-1:0];
  localparam logic [C5_W-1:0]  C5  = C5_FULL[C5_W-1:0];
  localparam logic [C6_W-1:0]  C6  = C6_FULL[C6_W-1:0];
  localparam logic [C7H_W-1:0] C7H = C7_FULL[C7_W-1:C7L_W];
  localparam logic [C7L_W-1:0] C7L = C7_FULL[C7L_W-1:0];
  localparam logic [C8_W-1:0]  C8  = C8_FULL[C8_W-1:0];

  // Coefficient product widths.
  localparam int P1_W = C1_W + T_W;
  localparam int P2_W = C2H_W + T2_W;
  localparam int P3_W = C3H_W + T3_W;
  localparam int P4_W = C4_W + 1 + SD_W;
  localparam int P5_W = C5_W + D_W;
  localparam int P6_W = C6_W + D2_W;
  localparam int P7_W = C7H_W + 1 + TSD_W;
  localparam int P8_W = C8_W + TD3_W;

  // Accumulator in units of 2^-80 m/s; the exact sum stays below 2^91.
  localparam int ACC_W   = 96;
  localparam int RND_POS = 70;

  // Alignment of each product into the accumulator.
  localparam int SH0  = 24;
  localparam int SH1  = 16;
  localparam int SH2H = 8 + C2L_W;
  localparam int SH2L = 8;
  localparam int SH3H = C3L_W;
  localparam int SH4  = 16;
  localparam int SH5  = 20;
  localparam int SH6  = 16;
  localparam int SH7H = 8 + C7L_W;
  localparam int SH7L = 8;
  localparam int SH8  = 4;

  typedef logic signed [ACC_W-1:0] acc_t;

  // Constant term plus the half-unit that turns truncation into rounding.
  localparam acc_t SUM_BASE =
    (ACC_W'(C0) << SH0) + (ACC_W'(1) << (RND_POS - 1));

  localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

  typedef struct packed {
    logic [T_W-1:0]          t;
    logic [D_W-1:0]          d;
    logic signed [SD_W-1:0]  sd;
    logic [T2_W-1:0]         t2;
    logic [D2_W-1:0]         d2;
    logic signed [TSD_W-1:0] tsd;
    logic [T3_W-1:0]         t3;
    logic [TD3_W-1:0]        td3;
  } pwr_t;

  typedef struct packed {
    logic [P1_W-1:0]        p1;
    logic [P2_W-1:0]        p2h;
    logic [P2_W-1:0]        p2l;
    logic [P3_W-1:0]        p3h;
    logic [P3_W-1:0]        p3l;
    logic signed [P4_W-1:0] p4;
    logic [P5_W-1:0]        p5;
    logic [P6_W-1:0]        p6;
    logic signed [P7_W-1:0] p7h;
    logic signed [P7_W-1:0] p7l;
    logic [P8_W-1:0]        p8;
  } prod_t;

endpackage

`default_nettype wire

[hw/rtl/sss_pwr.sv]
// ----------------------------------------------------------------------------
// sss_pwr: input clamp and operand powers
// Three register stages: clamp, squares and cross products, cubes.
// ----------------------------------------------------------------------------
`default_nettype none

module sss_pwr (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                up_valid,
  output logic                                     up_stall,
  input  wire logic signed [sss_pkg::TEMP_W-1:0]   temperature,
  input  wire logic [sss_pkg::SAL_W-1:0]           salinity,
  input  wire logic signed [sss_pkg::DEPTH_W-1:0]  depth,
  output logic                                     dn_valid,
  input  wire logic                                dn_stall,
  output sss_pkg::pwr_t                            dn_data
);

  localparam int TW   = sss_pkg::T_W;
  localparam int DW   = sss_pkg::D_W;
  localparam int T2W  = sss_pkg::T2_W;
  localparam int D2W  = sss_pkg::D2_W;
  localparam int TSDW = sss_pkg::TSD_W;
  localparam int TDW  = sss_pkg::TD_W;
  localparam int T3W  = sss_pkg::T3_W;
  localparam int TD3W = sss_pkg::TD3_W;

  logic                              v1, v2;
  logic                              adv1, adv2, adv3;
  logic [TW-1:0]                     t_clamp;
  logic [DW-1:0]                     d_clamp;
  logic [sss_pkg::SAL_W-1:0]         s_clamp;
  logic signed [sss_pkg::SD_W-1:0]   sd_clamp;

  logic [TW-1:0]                     t_1;
  logic [DW-1:0]                     d_1;
  logic signed [sss_pkg::SD_W-1:0]   sd_1;

  logic [TW-1:0]                     t_2;
  logic [DW-1:0]                     d_2;
  logic signed [sss_pkg::SD_W-1:0]   sd_2;
  logic [T2W-1:0]                    t2_2;
  logic [D2W-1:0]                    d2_2;
  logic signed [TSDW-1:0]            tsd_2;
  logic [TDW-1:0]                    td_2;

  // A stage moves on when it is empty or the stage after it moves.
  assign adv3     = !dn_valid || !dn_stall;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign up_stall = !adv1;

  // Negative temperature and depth read as zero; salinity stops at 40 ppt.
  assign t_clamp  = temperature[sss_pkg::TEMP_W-1] ? '0 : temperature[TW-1:0];
  assign d_clamp  = depth[sss_pkg::DEPTH_W-1] ? '0 : depth[DW-1:0];
  assign s_clamp  = (salinity > sss_pkg::SAL_MAX) ? sss_pkg::SAL_MAX : salinity;
  assign sd_clamp = $signed({1'b0, s_clamp}) - sss_pkg::SAL_REF;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= up_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv3) begin
        dn_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      t_1  <= t_clamp;
      d_1  <= d_clamp;
      sd_1 <= sd_clamp;
    end
    if (adv2) begin
      t_2   <= t_1;
      d_2   <= d_1;
      sd_2  <= sd_1;
      t2_2  <= T2W'(t_1) * T2W'(t_1);
      d2_2  <= D2W'(d_1) * D2W'(d_1);
      tsd_2 <= TSDW'($signed({1'b0, t_1})) * TSDW'(sd_1);
      td_2  <= TDW'(t_1) * TDW'(d_1);
    end
    if (adv3) begin
      dn_data.t   <= t_2;
      dn_data.d   <= d_2;
      dn_data.sd  <= sd_2;
      dn_data.t2  <= t2_2;
      dn_data.d2  <= d2_2;
      dn_data.tsd <= tsd_2;
      dn_data.t3  <= T3W'(t2_2) * T3W'(t_2);
      dn_data.td3 <= TD3W'(td_2) * TD3W'(d2_2);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sss_coef.sv]
// ----------------------------------------------------------------------------
// sss_coef: coefficient multiply stage
// Scales every power by its fixed-point coefficient in one register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sss_coef (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           up_valid,
  output logic                up_stall,
  input  sss_pkg::pwr_t       up_data,
  output logic                dn_valid,
  input  wire logic           dn_stall,
  output sss_pkg::prod_t      dn_data
);

  localparam int P1W = sss_pkg::P1_W;
  localparam int P2W = sss_pkg::P2_W;
  localparam int P3W = sss_pkg::P3_W;
  localparam int P4W = sss_pkg::P4_W;
  localparam int P5W = sss_pkg::P5_W;
  localparam int P6W = sss_pkg::P6_W;
  localparam int P7W = sss_pkg::P7_W;
  localparam int P8W = sss_pkg::P8_W;

  // Signed copies of the coefficients that meet signed operands.
  localparam logic signed [sss_pkg::C4_W:0]  C4S  = {1'b0, sss_pkg::C4};
  localparam logic signed [sss_pkg::C7H_W:0] C7HS = {1'b0, sss_pkg::C7H};
  localparam logic signed [sss_pkg::C7L_W:0] C7LS = {1'b0, sss_pkg::C7L};

  logic adv;

  assign adv      = !dn_valid || !dn_stall;
  assign up_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (adv) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dn_data.p1  <= P1W'(sss_pkg::C1) * P1W'(up_data.t);
      dn_data.p2h <= P2W'(sss_pkg::C2H) * P2W'(up_data.t2);
      dn_data.p2l <= P2W'(sss_pkg::C2L) * P2W'(up_data.t2);
      dn_data.p3h <= P3W'(sss_pkg::C3H) * P3W'(up_data.t3);
      dn_data.p3l <= P3W'(sss_pkg::C3L) * P3W'(up_data.t3);
      dn_data.p4  <= P4W'(C4S) * P4W'(up_data.sd);
      dn_data.p5  <= P5W'(sss_pkg::C5) * P5W'(up_data.d);
      dn_data.p6  <= P6W'(sss_pkg::C6) * P6W'(up_data.d2);
      dn_data.p7h <= P7W'(C7HS) * P7W'(up_data.tsd);
      dn_data.p7l <= P7W'(C7LS) * P7W'(up_data.tsd);
      dn_data.p8  <= P8W'(sss_pkg::C8) * P8W'(up_data.td3);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sss_sum.sv]
// ----------------------------------------------------------------------------
// sss_sum: exact adder tree, rounding and saturation
// Four register stages reduce the aligned terms to one result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sss_sum (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         up_valid,
  output logic                              up_stall,
  input  sss_pkg::prod_t                    up_data,
  output logic                              dn_valid,
  input  wire logic                         dn_stall,
  output logic [sss_pkg::SPEED_W-1:0]       sound_speed
);

  localparam int AW = sss_pkg::ACC_W;
  localparam int RP = sss_pkg::RND_POS;
  localparam int SW = sss_pkg::SPEED_W;

  logic          va, vb, vc;
  logic          adva, advb, advc, advd;
  sss_pkg::acc_t t1, t2h, t2l, t3h, t3l, t4, t5, t6, t7h, t7l, t8;
  sss_pkg::acc_t a0, a1, a2, a3, a4, a5;
  sss_pkg::acc_t b0, b1, b2;
  sss_pkg::acc_t c0, c1;
  sss_pkg::acc_t total;
  logic [SW-1:0] sound_speed_next;

  assign advd     = !dn_valid || !dn_stall;
  assign advc     = !vc || advd;
  assign advb     = !vb || advc;
  assign adva     = !va || advb;
  assign up_stall = !adva;

  // Align every product to units of 2^-80 m/s.
  assign t1  = AW'(up_data.p1)  << sss_pkg::SH1;
  assign t2h = AW'(up_data.p2h) << sss_pkg::SH2H;
  assign t2l = AW'(up_data.p2l) << sss_pkg::SH2L;
  assign t3h = AW'(up_data.p3h) << sss_pkg::SH3H;
  assign t3l = AW'(up_data.p3l);
  assign t4  = AW'(up_data.p4)  << sss_pkg::SH4;
  assign t5  = AW'(up_data.p5)  << sss_pkg::SH5;
  assign t6  = AW'(up_data.p6)  << sss_pkg::SH6;
  assign t7h = AW'(up_data.p7h) << sss_pkg::SH7H;
  assign t7l = AW'(up_data.p7l) << sss_pkg::SH7L;
  assign t8  = AW'(up_data.p8)  << sss_pkg::SH8;

  // Rounding half up already sits in the constant term, so a floor is enough.
  assign total = c0 + c1;

  always_comb begin
    if (total[AW-1]) begin
      sound_speed_next = '0;
    end else if (|total[AW-2:RP+SW]) begin
      sound_speed_next = sss_pkg::SPEED_MAX;
    end else begin
      sound_speed_next = total[RP+SW-1:RP];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va       <= 1'b0;
      vb       <= 1'b0;
      vc       <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (adva) begin
        va <= up_valid;
      end
      if (advb) begin
        vb <= va;
      end
      if (advc) begin
        vc <= vb;
      end
      if (advd) begin
        dn_valid <= vc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adva) begin
      a0 <= t1 - t2h;
      a1 <= t3h - t2l;
      a2 <= t3l - t7h;
      a3 <= t4 - t7l;
      a4 <= t5 - t8;
      a5 <= sss_pkg::SUM_BASE + t6;
    end
    if (advb) begin
      b0 <= a0 + a1;
      b1 <= a2 + a3;
      b2 <= a4 + a5;
    end
    if (advc) begin
      c0 <= b0 + b1;
      c1 <= b2;
    end
    if (advd) begin
      sound_speed <= sound_speed_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/seawater_sound_speed_top.sv]
// ----------------------------------------------------------------------------
// seawater_sound_speed_top: Mackenzie seawater sound speed pipeline
// Computes the nine-term sound speed equation exactly in fixed point.
// ----------------------------------------------------------------------------
//
// Channel | Dir | Handshake                   | Fields
// sample  | in  | sample_valid / sample_stall | temperature, salinity, depth
// speed   | out | speed_valid / speed_stall   | sound_speed
//
// One item enters per cycle while sample_stall is low; the depth
// is set by eight register stages: clamp, squares, cubes, one coefficient
// multiply stage and a four-level adder tree whose last stage is the output.
// Reset clears only the valid bits of the stages.
// A stall on the speed channel fills empty stages first; sample_stall rises
// only when every stage holds an item.
//
`default_nettype none

module seawater_sound_speed_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                sample_valid,
  output logic                                     sample_stall,
  input  wire logic signed [sss_pkg::TEMP_W-1:0]   temperature,
  input  wire logic [sss_pkg::SAL_W-1:0]           salinity,
  input  wire logic signed [sss_pkg::DEPTH_W-1:0]  depth,
  output logic                                     speed_valid,
  input  wire logic                                speed_stall,
  output logic [sss_pkg::SPEED_W-1:0]              sound_speed
);

  // Items flow: powers of the clamped inputs, then coefficient products,
  // then the exact sum with rounding and saturation.
  logic           pwr_valid, pwr_stall;
  sss_pkg::pwr_t  pwr_data;
  logic           prod_valid, prod_stall;
  sss_pkg::prod_t prod_data;

  sss_pwr u_pwr (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (sample_valid),
    .up_stall    (sample_stall),
    .temperature (temperature),
    .salinity    (salinity),
    .depth       (depth),
    .dn_valid    (pwr_valid),
    .dn_stall    (pwr_stall),
    .dn_data     (pwr_data)
  );

  sss_coef u_coef (
    .clk      (clk),
    .rst      (rst),
    .up_valid (pwr_valid),
    .up_stall (pwr_stall),
    .up_data  (pwr_data),
    .dn_valid (prod_valid),
    .dn_stall (prod_stall),
    .dn_data  (prod_data)
  );

  sss_sum u_sum (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (prod_valid),
    .up_stall    (prod_stall),
    .up_data     (prod_data),
    .dn_valid    (speed_valid),
    .dn_stall    (speed_stall),
    .sound_speed (sound_speed)
  );

  // A cycle in which the output side moves freely and no reset intervenes.
  logic flow_ok;
  assign flow_ok = !speed_stall && !rst;

  // With an empty output register nothing upstream can be blocked.
  assert property (@(posedge clk) disable iff (rst)
    !speed_valid |-> !sample_stall)
    else $error("sample stalled while the output register is empty");

  // Reset empties the output register.
  assert property (@(posedge clk) $past(rst) |-> !speed_valid)
    else $error("result shown right after reset");

  // An accepted item reaches the output if the output side flows freely and no reset intervenes.
  assert property (@(posedge clk) disable iff (rst)
    ($past(sample_valid && !sample_stall && !rst, 8) &&
     $past(flow_ok, 1) && $past(flow_ok, 2) && $past(flow_ok, 3) &&
     $past(flow_ok, 4) && $past(flow_ok, 5) && $past(flow_ok, 6) &&
     $past(flow_ok, 7)) |-> speed_valid)
    else $error("item did not arrive after the pipeline latency");

endmodule

`default_nettype wire

[sim/seawater_sound_speed_top_test.sv]
// ----------------------------------------------------------------------------
// seawater_sound_speed_top_test: self-checking bench for the sound speed pipe
// Drives temperature, salinity and depth items through the valid/stall sample
// channel and checks every sound speed result against an exact integer
// evaluation of the Mackenzie equation kept inside the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module seawater_sound_speed_top_test;

  // Port field widths.
  localparam int TEMP_W  = sss_pkg::TEMP_W;
  localparam int SAL_W   = sss_pkg::SAL_W;
  localparam int DEPTH_W = sss_pkg::DEPTH_W;
  localparam int SPEED_W = sss_pkg::SPEED_W;

  // Clamp and reference points of the salinity input, in 1/256 ppt.
  localparam int unsigned SAL_CLAMP_CODE = 10240;
  localparam int SAL_35PPT_CODE = 8960;
  localparam logic [SPEED_W-1:0] SPEED_LIMIT = {SPEED_W{1'b1}};
  localparam int MAX_REPORTS = 10;

  // One expected result, with the item that produced it for reporting.
  typedef struct {
    logic signed [TEMP_W-1:0]  temp;
    logic [SAL_W-1:0]          sal;
    logic signed [DEPTH_W-1:0] dep;
    logic [SPEED_W-1:0]        speed;
  } speed_expect_t;

  logic clk;
  logic rst;
  logic sample_valid;
  logic sample_stall;
  logic signed [TEMP_W-1:0] temperature;
  logic [SAL_W-1:0] salinity;
  logic signed [DEPTH_W-1:0] depth;
  logic speed_valid;
  logic speed_stall;
  logic [SPEED_W-1:0] sound_speed;

  speed_expect_t speed_expected_q[$];
  int mismatch_count;

  // Knobs shared between the test tasks and the two idling processes.
  bit tx_jitter;
  bit rx_jitter;
  int rx_hold_request;

  seawater_sound_speed_top dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .temperature  (temperature),
    .salinity     (salinity),
    .depth        (depth),
    .speed_valid  (speed_valid),
    .speed_stall  (speed_stall),
    .sound_speed  (sound_speed)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Exact evaluation of the sound speed.
  // Every coefficient is round-half-up(coef * 2^56) taken from its decimal
  // mantissa and exponent; each term is formed exactly, aligned to 2^-80 m/s
  // and summed modulo 2^128, then the sum is rounded half up to 2^-10 m/s.
  // --------------------------------------------------------------------------
  function automatic logic [127:0] scaled_coef(int unsigned mant, int unsigned exp10);
    logic [127:0] pow5;
    int k;
    pow5 = 128'd1;
    for (k = 0; k < exp10; k++) pow5 = pow5 * 128'd5;
    return ((128'(mant) << (57 - exp10)) + pow5) / (pow5 * 128'd2);
  endfunction

  function automatic logic [127:0] mackenzie_term(int unsigned mant, int unsigned exp10,
                                                  bit negate, logic [31:0] f1,
                                                  logic [31:0] f2, logic [31:0] f3,
                                                  logic [31:0] f4, int unsigned align);
    logic [127:0] v;
    v = scaled_coef(mant, exp10) * 128'(f1) * 128'(f2) * 128'(f3) * 128'(f4);
    v = v << align;
    if (negate) v = -v;
    return v;
  endfunction

  function automatic logic [SPEED_W-1:0] mackenzie_speed(logic signed [TEMP_W-1:0] temp,
                                                         logic [SAL_W-1:0] sal,
                                                         logic signed [DEPTH_W-1:0] dep);
    logic [31:0] t;
    logic [31:0] d;
    logic [31:0] s;
    logic [31:0] sal_mag;
    int sal_dev;
    bit fresher;
    logic [127:0] acc;
    // Negative temperature and depth count as zero; salinity stops at 40 ppt.
    t = temp[TEMP_W-1] ? 32'd0 : 32'(temp[TEMP_W-2:0]);
    d = dep[DEPTH_W-1] ? 32'd0 : 32'(dep[DEPTH_W-2:0]);
    s = (sal > SAL_CLAMP_CODE) ? SAL_CLAMP_CODE : 32'(sal);
    sal_dev = int'(s) - SAL_35PPT_CODE;
    fresher = sal_dev < 0;
    sal_mag = fresher ? 32'(-sal_dev) : 32'(sal_dev);

    acc = '0;
    acc += mackenzie_term(144896, 2, 1'b0, 1, 1, 1, 1, 24);
    acc += mackenzie_term(4591, 3, 1'b0, t, 1, 1, 1, 16);
    acc += mackenzie_term(5304, 5, 1'b1, t, t, 1, 1, 8);
    acc += mackenzie_term(2374, 7, 1'b0, t, t, t, 1, 0);
    acc += mackenzie_term(134, 2, fresher, sal_mag, 1, 1, 1, 16);
    acc += mackenzie_term(163, 4, 1'b0, d, 1, 1, 1, 20);
    acc += mackenzie_term(1675, 10, 1'b0, d, d, 1, 1, 16);
    acc += mackenzie_term(1025, 5, !fresher, t, sal_mag, 1, 1, 8);
    acc += mackenzie_term(7139, 16, 1'b1, t, d, d, d, 4);
    acc += (128'd1 << 69);

    if (acc[127]) return '0;
    if (acc[127:70] > 58'(SPEED_LIMIT)) return SPEED_LIMIT;
    return acc[70 + SPEED_W - 1:70];
  endfunction

  // Gap lengths for both sides: one draw in ten gives a long gap, the rest a short one.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // --------------------------------------------------------------------------
  // Sample sender. Valid is raised with the payload and held, payload
  // unchanged, until an edge sees stall low. The expectation is queued at
  // that accepting edge. An optional gap before the item lowers valid first;
  // the gap is never empty, so valid never gets two updates in one time step.
  // --------------------------------------------------------------------------
  task automatic send_sample(logic signed [TEMP_W-1:0] temp, logic [SAL_W-1:0] sal,
                             logic signed [DEPTH_W-1:0] dep);
    speed_expect_t exp_item;
    if (tx_jitter && $urandom_range(0, 3) == 0) begin
      sample_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
    sample_valid <= 1'b1;
    temperature <= temp;
    salinity <= sal;
    depth <= dep;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    exp_item.temp = temp;
    exp_item.sal = sal;
    exp_item.dep = dep;
    exp_item.speed = mackenzie_speed(temp, sal, dep);
    speed_expected_q.push_back(exp_item);
  endtask

  // Random item: mostly inside the physical ranges, sometimes anywhere in
  // the field so that every bit of every input toggles.
  task automatic send_random_sample();
    logic signed [TEMP_W-1:0] temp;
    logic [SAL_W-1:0] sal;
    logic signed [DEPTH_W-1:0] dep;
    if ($urandom_range(0, 3) != 0) begin
      temp = TEMP_W'(int'($urandom_range(0, 12800)) - 2560);
      sal = SAL_W'($urandom_range(0, 11000));
      dep = DEPTH_W'(int'($urandom_range(0, 131071 + 2000)) - 2000);
    end else begin
      temp = TEMP_W'($urandom);
      sal = SAL_W'($urandom);
      dep = DEPTH_W'($urandom);
    end
    send_sample(temp, sal, dep);
  endtask

  // Drops valid and waits until every queued result has come back.
  task automatic drain_results();
    sample_valid <= 1'b0;
    do @(posedge clk); while (speed_expected_q.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Speed receiver. One stall decision per edge: a hold requested by a test
  // is counted down here, otherwise random short and long stalls are drawn
  // while receiver jitter is enabled.
  // --------------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left = 0;
    speed_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_request > 0) begin
        stall_left = rx_hold_request;
        rx_hold_request = 0;
      end else if (stall_left == 0 && rx_jitter && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        speed_stall <= 1'b1;
        stall_left--;
      end else begin
        speed_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: every accepted result is compared with the oldest
  // expectation. Results with nothing pending are failures as well.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    speed_expect_t exp_item;
    if (!rst && speed_valid === 1'b1 && speed_stall === 1'b0) begin
      if (speed_expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected sound_speed %0d with no item pending", sound_speed);
      end else begin
        exp_item = speed_expected_q.pop_front();
        if (sound_speed !== exp_item.speed) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("sound_speed mismatch: T=%0d S=%0d D=%0d expected %0d got %0d",
                     exp_item.temp, exp_item.sal, exp_item.dep, exp_item.speed,
                     sound_speed);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes, clamps on every input and the 35 ppt pivot where the
  // salinity terms change sign. Sent back to back without idling.
  task automatic test_field_corners();
    send_sample(-15'sd16384, 14'd0, -18'sd131072);
    send_sample(15'sd16383, 14'd16383, 18'sd131071);
    send_sample(15'sd0, 14'd0, 18'sd0);
    send_sample(-15'sd1, 14'd8960, -18'sd1);
    send_sample(15'sd1, 14'd8959, 18'sd1);
    send_sample(15'sd1, 14'd8961, 18'sd1);
    send_sample(-15'sd2560, 14'd8960, 18'sd0);
    send_sample(15'sd10240, 14'd10240, 18'sd0);
    send_sample(15'sd10240, 14'd10241, 18'sd131071);
    send_sample(15'sd10240, 14'd0, 18'sd131071);
    send_sample(15'sd16383, 14'd0, 18'sd0);
    send_sample(15'sd16383, 14'd10240, 18'sd131071);
    send_sample(15'sd0, 14'd16383, 18'sd131071);
    send_sample(15'sd16383, 14'd0, -18'sd131072);
    send_sample(-15'sd16384, 14'd16383, 18'sd131071);
    send_sample(15'sd2560, 14'd8960, 18'sd16000);
    send_sample(15'sd5120, 14'd9000, 18'sd65536);
    send_sample(15'sd256, 14'd256, 18'sd16);
    send_sample(15'sd8191, 14'd5461, 18'sd43690);
    send_sample(15'sd5461, 14'd10922, 18'sd87381);
  endtask

  // Main random stream with idling on both sides.
  task automatic test_random_stream(int count);
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
    repeat (count) send_random_sample();
  endtask

  // The receiver holds off long enough for every stage to fill while the
  // sender keeps offering, so sample_stall must rise and later release.
  task automatic test_output_backpressure();
    tx_jitter = 1'b0;
    rx_jitter = 1'b0;
    rx_hold_request = 64;
    repeat (30) send_random_sample();
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
  endtask

  // Bursts separated by full drains so the pipe restarts from empty.
  task automatic test_drain_restart();
    repeat (3) begin
      repeat ($urandom_range(5, 15)) send_random_sample();
      drain_results();
    end
  endtask

  // A stretch at full rate with no idling on either side.
  task automatic test_full_rate();
    tx_jitter = 1'b0;
    rx_jitter = 1'b0;
    repeat (60) send_random_sample();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    mismatch_count = 0;
    tx_jitter = 1'b0;
    rx_jitter = 1'b0;
    rx_hold_request = 0;
    rst <= 1'b1;
    sample_valid <= 1'b0;
    temperature <= '0;
    salinity <= '0;
    depth <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_field_corners();
    test_random_stream(200);
    test_output_backpressure();
    test_drain_restart();
    test_random_stream(200);
    test_full_rate();
    test_output_backpressure();

    // Let the pipe empty, then watch a little longer for stray results.
    drain_results();
    repeat (20) @(posedge clk);
    mismatch_count += speed_expected_q.size();
    if (mismatch_count == 0)
      $display("seawater_sound_speed_top verification clean");
    else
      $display("seawater_sound_speed_top verification failed");
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #3000000;
    $display("seawater_sound_speed_top verification failed");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/sss_pkg.sv
hw/rtl/sss_pwr.sv
hw/rtl/sss_coef.sv
hw/rtl/sss_sum.sv
hw/rtl/seawater_sound_speed_top.sv
sim/seawater_sound_speed_top_test.sv
